>>> rtl/archive_url_stream_parser_top_assert.svh
// Assertion macros shared by the archive URL stream parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ARCHIVE_URL_STREAM_PARSER_TOP_ASSERT_SVH
`define ARCHIVE_URL_STREAM_PARSER_TOP_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define AUSP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check of the cycle that follows a reset cycle.
`define AUSP_ASSERT_AFTER_RESET(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

>>> rtl/ausp_pkg.sv
// Package for the archive URL stream parser: result item and bundle types,
// part codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ausp_pkg;

    // Part codes carried on each result item
    localparam logic [1:0] PART_BACKEND = 2'd0;
    localparam logic [1:0] PART_ARCHIVE = 2'd1;
    localparam logic [1:0] PART_ENTRY   = 2'd2;
    localparam logic [1:0] PART_END     = 2'd3;

    // Most results one URL character can produce
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0] part;
        logic [7:0] data;
        logic       ok;
        logic       last;
    } item_t;

    // All results caused by one accepted character, in emission order
    typedef struct packed {
        logic [CNT_W-1:0]             cnt;
        item_t [MAX_RESULTS-1:0]      items;
    } bundle_t;

endpackage

`default_nettype wire

>>> rtl/ausp_front.sv
// Front end of the archive URL stream parser: per-character parse state and
// classification into a bundle of result items. Depends on ausp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ausp_front #(
    parameter int LENGTH_BITS = ausp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [7:0]        s_in_byte,
    input  wire logic              s_in_last,
    output logic                   push,
    output ausp_pkg::bundle_t      bundle
);

    localparam int PW = LENGTH_BITS + 4;

    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [3:0] POS_SCHEME_DONE  = 4'd9;
    localparam logic [3:0] POS_BACKEND_SEEN = 4'd10;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_BACKEND,
        PH_LENGTH,
        PH_ARCHIVE,
        PH_ABAR,
        PH_ESTART,
        PH_ENTRY
    } phase_t;

    typedef struct packed {
        phase_t                                     phase;
        logic [1:0]                                 hold;
        logic [7:0]                                 held;
        logic                                       dot;
        logic                                       enon;
        logic                                       failed;
        logic [ausp_pkg::CNT_W-1:0]                 cnt;
        ausp_pkg::item_t [ausp_pkg::MAX_RESULTS-1:0] items;
    } fe_work_t;

    function automatic logic [7:0] scheme_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h75; // u
            4'd1:    ch = 8'h6E; // n
            4'd2:    ch = 8'h70; // p
            4'd3:    ch = 8'h61; // a
            4'd4:    ch = 8'h63; // c
            4'd5:    ch = 8'h6B; // k
            4'd6:    ch = 8'h3A; // :
            4'd7:    ch = 8'h2F; // /
            4'd8:    ch = 8'h2F; // /
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // 16 flags a non-hex character
    function automatic logic [4:0] hexval(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CH_0 && c <= CH_9) begin
            v = 5'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = 5'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = 5'(c - CH_UA + 8'd10);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    function automatic fe_work_t emit(input fe_work_t w, input logic [1:0] part,
                                      input logic [7:0] b, input logic ok,
                                      input logic last);
        fe_work_t r;
        r = w;
        if (r.cnt < ausp_pkg::CNT_W'(ausp_pkg::MAX_RESULTS)) begin
            r.items[r.cnt].part = part;
            r.items[r.cnt].data = b;
            r.items[r.cnt].ok   = ok;
            r.items[r.cnt].last = last;
            r.cnt = r.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic fe_work_t entry_put(input fe_work_t w, input logic [7:0] b);
        fe_work_t   r;
        logic [7:0] bb;
        logic       skip;
        r    = w;
        bb   = (b == CH_BSL) ? CH_SLASH : b;
        skip = 1'b0;
        if (r.phase == PH_ESTART) begin
            if (r.dot) begin
                // leading dot resolved: "./" drops both, otherwise dot goes out
                r.dot   = 1'b0;
                r.phase = PH_ENTRY;
                if (bb == CH_SLASH) begin
                    skip = 1'b1;
                end else begin
                    r      = emit(r, ausp_pkg::PART_ENTRY, CH_DOT, 1'b0, 1'b0);
                    r.enon = 1'b1;
                end
            end else if (bb == CH_DOT) begin
                r.dot = 1'b1;
                skip  = 1'b1;
            end else begin
                r.phase = PH_ENTRY;
            end
        end
        if (!skip) begin
            r      = emit(r, ausp_pkg::PART_ENTRY, bb, 1'b0, 1'b0);
            r.enon = 1'b1;
        end
        return r;
    endfunction

    function automatic fe_work_t sink(input fe_work_t w, input logic [1:0] part,
                                      input logic [7:0] b);
        fe_work_t r;
        if (part == ausp_pkg::PART_ARCHIVE) begin
            r = emit(w, ausp_pkg::PART_ARCHIVE, b, 1'b0, 1'b0);
        end else begin
            r = entry_put(w, b);
        end
        return r;
    endfunction

    // percent decoding with up to two held characters
    function automatic fe_work_t feed(input fe_work_t w, input logic [1:0] part,
                                      input logic [7:0] c);
        fe_work_t   r;
        logic [4:0] hc;
        logic [4:0] hh;
        logic       done;
        r    = w;
        hc   = hexval(c);
        hh   = hexval(w.held);
        done = 1'b0;
        if (r.hold == 2'd1) begin
            if (!hc[4]) begin
                r.held = c;
                r.hold = 2'd2;
                done   = 1'b1;
            end else begin
                r.hold = 2'd0;
                r      = sink(r, part, CH_PCT);
            end
        end else if (r.hold == 2'd2) begin
            if (!hc[4]) begin
                r.hold = 2'd0;
                r      = sink(r, part, {hh[3:0], hc[3:0]});
                done   = 1'b1;
            end else begin
                r.hold = 2'd0;
                r      = sink(r, part, CH_PCT);
                r      = sink(r, part, w.held);
            end
        end
        if (!done) begin
            if (c == CH_PCT) begin
                r.hold = 2'd1;
            end else begin
                r = sink(r, part, c);
            end
        end
        return r;
    endfunction

    function automatic fe_work_t flush(input fe_work_t w, input logic [1:0] part);
        fe_work_t r;
        r      = w;
        r.hold = 2'd0;
        if (w.hold != 2'd0) begin
            r = sink(r, part, CH_PCT);
        end
        if (w.hold == 2'd2) begin
            r = sink(r, part, w.held);
        end
        if (part == ausp_pkg::PART_ENTRY && r.dot) begin
            r.dot   = 1'b0;
            r.phase = PH_ENTRY;
            r       = emit(r, ausp_pkg::PART_ENTRY, CH_DOT, 1'b0, 1'b0);
            r.enon  = 1'b1;
        end
        return r;
    endfunction

    function automatic fe_work_t fail(input fe_work_t w);
        fe_work_t r;
        r        = w;
        r.failed = 1'b1;
        r.hold   = 2'd0;
        r.dot    = 1'b0;
        return r;
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [3:0]             pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   seen_reg, seen_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [1:0]             hold_reg, hold_next;
    logic [7:0]             held_reg, held_next;
    logic                   dot_reg, dot_next;
    logic                   enon_reg, enon_next;
    logic                   anon_reg, anon_next;
    logic                   failed_reg, failed_next;
    logic                   ended_reg, ended_next;

    fe_work_t               w;
    logic                   end_ok;
    logic [3:0]             digit;
    logic [PW-1:0]          len_ext;
    logic [PW-1:0]          len_prod;

    always_comb begin
        w        = '0;
        w.phase  = phase_reg;
        w.hold   = hold_reg;
        w.held   = held_reg;
        w.dot    = dot_reg;
        w.enon   = enon_reg;
        w.failed = failed_reg;

        pos_next   = pos_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        anon_next  = anon_reg;
        ended_next = ended_reg;
        end_ok     = 1'b0;

        // length * 10 + digit, four guard bits catch saturation
        digit    = 4'(s_in_byte - CH_0);
        len_ext  = PW'(len_reg);
        len_prod = (len_ext << 3) + (len_ext << 1) + PW'(digit);

        if (!(failed_reg || ended_reg)) begin
            if (phase_reg != PH_PREFIX && (s_in_byte == CH_QUES || s_in_byte == CH_HASH)) begin
                if (phase_reg == PH_ESTART || phase_reg == PH_ENTRY) begin
                    w          = flush(w, ausp_pkg::PART_ENTRY);
                    ended_next = 1'b1;
                end else begin
                    w = fail(w);
                end
            end else begin
                case (phase_reg)
                    PH_PREFIX: begin
                        if (pos_reg >= POS_SCHEME_DONE || s_in_byte != scheme_char(pos_reg)) begin
                            w = fail(w);
                        end else begin
                            pos_next = pos_reg + 4'd1;
                            if (pos_next == POS_SCHEME_DONE) begin
                                w.phase = PH_BACKEND;
                            end
                        end
                    end
                    PH_BACKEND: begin
                        if (s_in_byte == CH_BAR) begin
                            if (pos_reg == POS_SCHEME_DONE) begin
                                w = fail(w);
                            end else begin
                                w.phase = PH_LENGTH;
                            end
                        end else begin
                            pos_next = POS_BACKEND_SEEN;
                            w = emit(w, ausp_pkg::PART_BACKEND, s_in_byte, 1'b0, 1'b0);
                        end
                    end
                    PH_LENGTH: begin
                        if (s_in_byte == CH_BAR) begin
                            if (!seen_reg) begin
                                w = fail(w);
                            end else begin
                                left_next = len_reg;
                                anon_next = (len_reg != '0);
                                w.phase   = (len_reg != '0) ? PH_ARCHIVE : PH_ABAR;
                            end
                        end else if (s_in_byte >= CH_0 && s_in_byte <= CH_9) begin
                            if (len_prod[PW-1:LENGTH_BITS] != 4'd0) begin
                                len_next = '1;
                                w        = fail(w);
                            end else begin
                                len_next  = len_prod[LENGTH_BITS-1:0];
                                seen_next = 1'b1;
                            end
                        end else begin
                            w = fail(w);
                        end
                    end
                    PH_ARCHIVE: begin
                        left_next = left_reg - 1'b1;
                        w = feed(w, ausp_pkg::PART_ARCHIVE, s_in_byte);
                        if (left_next == '0) begin
                            w       = flush(w, ausp_pkg::PART_ARCHIVE);
                            w.phase = PH_ABAR;
                        end
                    end
                    PH_ABAR: begin
                        if (s_in_byte == CH_BAR) begin
                            w.phase = PH_ESTART;
                            w.hold  = 2'd0;
                        end else begin
                            w = fail(w);
                        end
                    end
                    PH_ESTART, PH_ENTRY: begin
                        w = feed(w, ausp_pkg::PART_ENTRY, s_in_byte);
                    end
                    default: begin
                        w = fail(w);
                    end
                endcase
            end
        end

        if (s_in_last) begin
            if (!w.failed && !ended_next && (w.phase == PH_ESTART || w.phase == PH_ENTRY)) begin
                w = flush(w, ausp_pkg::PART_ENTRY);
            end
            end_ok = !w.failed && (w.phase == PH_ESTART || w.phase == PH_ENTRY) &&
                     anon_next && w.enon;
            w = emit(w, ausp_pkg::PART_END, 8'd0, end_ok, 1'b1);
        end

        phase_next  = w.phase;
        hold_next   = w.hold;
        held_next   = w.held;
        dot_next    = w.dot;
        enon_next   = w.enon;
        failed_next = w.failed;

        // end of URL: everything back to the reset state
        if (s_in_last) begin
            phase_next  = PH_PREFIX;
            pos_next    = 4'd0;
            len_next    = '0;
            seen_next   = 1'b0;
            left_next   = '0;
            hold_next   = 2'd0;
            held_next   = 8'd0;
            dot_next    = 1'b0;
            enon_next   = 1'b0;
            anon_next   = 1'b0;
            failed_next = 1'b0;
            ended_next  = 1'b0;
        end

        bundle.cnt   = w.cnt;
        bundle.items = w.items;
        push         = s_valid && s_ready && (w.cnt != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREFIX;
            pos_reg    <= 4'd0;
            len_reg    <= '0;
            seen_reg   <= 1'b0;
            left_reg   <= '0;
            hold_reg   <= 2'd0;
            held_reg   <= 8'd0;
            dot_reg    <= 1'b0;
            enon_reg   <= 1'b0;
            anon_reg   <= 1'b0;
            failed_reg <= 1'b0;
            ended_reg  <= 1'b0;
        end else if (s_valid && s_ready) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            left_reg   <= left_next;
            hold_reg   <= hold_next;
            held_reg   <= held_next;
            dot_reg    <= dot_next;
            enon_reg   <= enon_next;
            anon_reg   <= anon_next;
            failed_reg <= failed_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ausp_queue.sv
// Bundle queue between front and back of the archive URL stream parser.
// Depends on ausp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "archive_url_stream_parser_top_assert.svh"

module ausp_queue #(
    parameter int QUEUE_DEPTH = ausp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire ausp_pkg::bundle_t  push_bundle,
    input  wire logic               pop,
    output ausp_pkg::bundle_t       head,
    output logic                    empty,
    output logic                    full
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ausp_pkg::bundle_t slots [QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_bundle;
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(QUEUE_DEPTH));

    `AUSP_ASSERT(a_no_push_full, aclk, aresetn, !(push && full), "push into full queue")
    `AUSP_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop && empty), "pop from empty queue")
    `AUSP_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(QUEUE_DEPTH), "queue count overrun")

endmodule

`default_nettype wire

>>> rtl/ausp_back.sv
// Back end of the archive URL stream parser: walks the head bundle and
// drives the result port through an output register. Depends on ausp_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "archive_url_stream_parser_top_assert.svh"

module ausp_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ausp_pkg::bundle_t  head,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_out_part,
    output logic [7:0]              m_out_byte,
    output logic                    m_out_ok,
    output logic                    m_out_last
);

    logic                       m_valid_reg;
    ausp_pkg::item_t            item_reg;
    logic [ausp_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       load;
    logic                       at_tail;

    assign load    = !empty && (!m_valid_reg || m_ready);
    assign at_tail = (idx_reg == head.cnt - 1'b1);
    assign pop     = load && at_tail;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = at_tail ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= head.items[idx_reg];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_part = item_reg.part;
    assign m_out_byte = item_reg.data;
    assign m_out_ok   = item_reg.ok;
    assign m_out_last = item_reg.last;

    `AUSP_ASSERT(a_last_is_end, aclk, aresetn, m_valid_reg && item_reg.last |-> item_reg.part == ausp_pkg::PART_END, "last flag on a byte item")
    `AUSP_ASSERT(a_mid_bundle_head, aclk, aresetn, idx_reg != '0 |-> !empty, "bundle walk without a head bundle")
    `AUSP_ASSERT_AFTER_RESET(a_reset_idle, aclk, aresetn, !m_valid_reg && idx_reg == '0, "result port busy after reset")

endmodule

`default_nettype wire

>>> rtl/archive_url_stream_parser_top.sv
// Archive URL stream parser, one URL character per request in, decoded parts
// out one result per request. A character is accepted in any cycle in which the
// bundle queue has a free slot, so a run of characters goes in at one per cycle;
// each character yields zero to five results, and the result port drains one
// result per cycle while m_ready is high, so sustained rate is one character
// per cycle whenever the results average at most one per character (backend,
// archive and entry bytes mostly give exactly one). The front parser updates its
// state in the cycle of acceptance and writes the whole bundle of results into a
// queue of QUEUE_DEPTH slots (four by default); the back end walks the head
// bundle into an output register, so the first result of a character passes
// through the queue slot and the output register to the result port. Percent
// escapes and a leading dot of the entry are held back, which is why one
// character can release several results. The end-of-URL result (part 3,
// last=1) carries ok=1 only for a clean parse with nonempty backend, archive
// and entry; after it the parser is back in its reset state. No clearing
// pass is needed after reset.
// Depends on ausp_pkg, ausp_front, ausp_queue and ausp_back.
`timescale 1ns / 1ps
`default_nettype none

module archive_url_stream_parser_top #(
    parameter int LENGTH_BITS = ausp_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = ausp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // character requests
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    // result requests
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_out_part,
    output logic [7:0]      m_out_byte,
    output logic            m_out_ok,
    output logic            m_out_last
);

    logic              q_push;
    ausp_pkg::bundle_t q_in_bundle;
    ausp_pkg::bundle_t q_head;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    // Front stalls only on a full queue, never on the result port directly.
    assign s_ready = !q_full;

    ausp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .push      (q_push),
        .bundle    (q_in_bundle)
    );

    // Characters that release nothing never occupy a queue slot.
    ausp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_bundle (q_in_bundle),
        .pop         (q_pop),
        .head        (q_head),
        .empty       (q_empty),
        .full        (q_full)
    );

    ausp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_part (m_out_part),
        .m_out_byte (m_out_byte),
        .m_out_ok   (m_out_ok),
        .m_out_last (m_out_last)
    );

endmodule

`default_nettype wire
